// ===== design/assert_macros.svh =====
// assertion macros shared by the decoder rtl
// clocked, reset-qualified forms of a plain and a next-cycle property
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define SDD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sdd_pkg.sv =====
// types and constants of the spectrum delta decoder
// no dependencies
`timescale 1ns / 1ps

package sdd_pkg;

  localparam int SpectrumBinsDefault = 1024;

  // fixed field widths
  localparam int BinW  = 10;
  localparam int RunW  = 11;
  localparam int CntW  = 12;
  localparam int ValW  = 32;

  // result kinds
  typedef enum logic [2:0] {
    KIND_TIMESTAMP = 3'd0,
    KIND_CAL1      = 3'd1,
    KIND_CAL2      = 3'd2,
    KIND_CAL3      = 3'd3,
    KIND_BIN       = 3'd4,
    KIND_RUN       = 3'd5,
    KIND_STATUS    = 3'd6
  } kind_e;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_CODE  = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_e;

  // group width codes
  localparam logic [3:0] WC_ZERO_RUN = 4'd0;
  localparam logic [3:0] WC_ABS_BYTE = 4'd1;
  localparam logic [3:0] WC_DELTA8   = 4'd2;
  localparam logic [3:0] WC_DELTA16  = 4'd3;
  localparam logic [3:0] WC_DELTA24  = 4'd4;
  localparam logic [3:0] WC_DELTA32  = 4'd5;

  // one result word
  typedef struct packed {
    kind_e             kind;
    logic [BinW-1:0]   bin;
    logic [ValW-1:0]   value;
    logic [RunW-1:0]   run;
    err_e              err;
    logic              done;
  } result_t;

  // number of payload bytes per value for a width code
  function automatic logic [2:0] value_bytes(input logic [3:0] code);
    logic [2:0] n;
    if (code <= WC_DELTA8) begin
      n = 3'd1;
    end else if (code == WC_DELTA16) begin
      n = 3'd2;
    end else if (code == WC_DELTA24) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

// ===== design/spectrum_delta_decoder_top.sv =====
// a byte word in the input register writes its result word into the result register when it advances
// throughput: one byte word per cycle while the result channel is not stalled; the state update for a byte is one short
//   add/compare path between the input register and the result register
// a byte that makes no result still waits only on its own turn in the input register
// reset (rst_ni low, asynchronous) clears the frame state, the input and result valids;
//   every byte marked frame_last returns the frame state to its reset value
`timescale 1ns / 1ps

// spectrum delta decoder, top level
// depends on sdd_pkg and assert_macros.svh
`include "assert_macros.svh"

module spectrum_delta_decoder_top
  import sdd_pkg::*;
#(
  parameter int SPECTRUM_BINS = SpectrumBinsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // byte input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             in_byte_i,
  input  logic                   frame_last_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             kind_o,
  output logic [BinW-1:0]        bin_index_o,
  output logic signed [ValW-1:0] value_word_o,
  output logic [RunW-1:0]        run_length_o,
  output logic [1:0]             error_code_o,
  output logic                   frame_done_o
);

  // next_bin must hold SPECTRUM_BINS itself
  localparam int NbW  = $clog2(SPECTRUM_BINS + 1);
  // room for next_bin plus a full group count without wrap
  localparam int SumW = ((NbW > CntW) ? NbW : CntW) + 1;

  // frame phases
  localparam logic [1:0] PH_WORDS = 2'd0;  // timestamp and calibration fields
  localparam logic [1:0] PH_GROUP = 2'd1;  // 16-bit group header
  localparam logic [1:0] PH_VALUE = 2'd2;  // values of a group
  localparam logic [1:0] PH_DROP  = 2'd3;  // rest of a frame after an error

  // ------------------------------------------------------------------
  // input register
  // ------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // ------------------------------------------------------------------
  // frame state
  // ------------------------------------------------------------------
  logic [1:0]      phase_q, phase_d;
  logic [3:0]      byte_pos_q, byte_pos_d;
  logic [31:0]     asm_q, asm_d;
  logic [31:0]     prev_q, prev_d;
  logic [CntW-1:0] left_q, left_d;
  logic [3:0]      wcode_q, wcode_d;
  logic [NbW-1:0]  next_bin_q, next_bin_d;
  err_e            err_latch_q, err_latch_d;

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  logic    out_valid_q;
  result_t out_q;

  // per-byte decode
  result_t         res;
  logic            have;    // byte completes a field, value or zero run
  logic            emit;    // byte produces a result word
  logic            advance; // input register hands its byte on this cycle
  logic            out_free;

  // group header decode
  logic [15:0]     hdr;
  logic [CntW-1:0] cnt;
  logic [3:0]      code;
  logic [SumW-1:0] bin_sum;

  // value assembly
  logic [1:0]      vpos;
  logic [31:0]     asm_val;
  logic [31:0]     delta;
  logic [31:0]     base;
  logic [31:0]     vsum;
  logic [2:0]      vcount;
  logic            vdone;
  logic [CntW-1:0] left_dec;

  logic [SumW-1:0] nb_q_wide;

  assign nb_q_wide = SumW'(next_bin_q);

  assign hdr     = {in_byte_q, asm_q[7:0]};
  assign cnt     = hdr[15:4];
  assign code    = hdr[3:0];
  assign bin_sum = nb_q_wide + SumW'(cnt);

  // value bytes arrive least significant first
  assign vpos     = byte_pos_q[1:0];
  assign asm_val  = asm_q | (32'(in_byte_q) << {vpos, 3'b000});
  assign vcount   = {1'b0, vpos} + 3'd1;
  assign vdone    = (vcount >= value_bytes(wcode_q));
  assign left_dec = left_q - CntW'(1);

  // sign-extend the delta; the absolute byte code adds to zero
  always_comb begin
    base = prev_q;
    unique case (wcode_q)
      WC_ZERO_RUN, WC_ABS_BYTE: begin
        base  = '0;
        delta = {24'd0, asm_val[7:0]};
      end
      WC_DELTA8:  delta = {{24{asm_val[7]}}, asm_val[7:0]};
      WC_DELTA16: delta = {{16{asm_val[15]}}, asm_val[15:0]};
      WC_DELTA24: delta = {{8{asm_val[23]}}, asm_val[23:0]};
      default:    delta = asm_val;
    endcase
  end

  assign vsum = base + delta;

  // ------------------------------------------------------------------
  // next state and result of the byte in the input register
  // ------------------------------------------------------------------
  always_comb begin
    phase_d     = phase_q;
    byte_pos_d  = byte_pos_q;
    asm_d       = asm_q;
    prev_d      = prev_q;
    left_d      = left_q;
    wcode_d     = wcode_q;
    next_bin_d  = next_bin_q;
    err_latch_d = err_latch_q;

    have      = 1'b0;
    res.kind  = KIND_STATUS;
    res.bin   = nb_q_wide[BinW-1:0];
    res.value = '0;
    res.run   = RunW'(1);
    res.err   = ERR_NONE;
    res.done  = in_last_q;

    unique case (phase_q)
      PH_WORDS: begin
        // four 32-bit fields shift in from the top
        asm_d      = {in_byte_q, asm_q[31:8]};
        byte_pos_d = byte_pos_q + 4'd1;
        if (byte_pos_q[1:0] == 2'd3) begin
          have      = 1'b1;
          res.kind  = kind_e'({1'b0, byte_pos_q[3:2]});
          res.value = asm_d;
          res.bin   = '0;
        end
        if (byte_pos_q == 4'd15) begin
          phase_d    = PH_GROUP;
          byte_pos_d = '0;
          asm_d      = '0;
        end else if (in_last_q) begin
          res.err = ERR_TRUNCATED;
        end
      end

      PH_GROUP: begin
        if (byte_pos_q == 4'd0) begin
          asm_d      = {24'd0, in_byte_q};
          byte_pos_d = 4'd1;
          if (in_last_q) begin
            res.err = ERR_TRUNCATED;
          end
        end else begin
          byte_pos_d = '0;
          asm_d      = '0;
          if (cnt != '0) begin
            priority if (code > WC_DELTA32) begin
              res.err = ERR_BAD_CODE;
            end else if (bin_sum > SumW'(SPECTRUM_BINS)) begin
              res.err = ERR_OVERFLOW;
            end else if (code == WC_ZERO_RUN) begin
              have       = 1'b1;
              res.kind   = KIND_RUN;
              res.run    = cnt[RunW-1:0];
              prev_d     = '0;
              next_bin_d = bin_sum[NbW-1:0];
            end else begin
              left_d  = cnt;
              wcode_d = code;
              phase_d = PH_VALUE;
            end
          end
          if (res.err != ERR_NONE && !in_last_q) begin
            // the error is reported now and again on the last byte
            err_latch_d = res.err;
            phase_d     = PH_DROP;
          end else if (res.err == ERR_NONE && in_last_q && phase_d == PH_VALUE) begin
            res.err = ERR_TRUNCATED;
          end
        end
      end

      PH_VALUE: begin
        asm_d      = asm_val;
        byte_pos_d = {1'b0, vcount};
        if (vdone) begin
          have       = 1'b1;
          res.kind   = KIND_BIN;
          res.value  = vsum;
          prev_d     = vsum;
          next_bin_d = next_bin_q + NbW'(1);
          left_d     = left_dec;
          byte_pos_d = '0;
          asm_d      = '0;
          if (left_dec == '0) begin
            phase_d = PH_GROUP;
          end
        end
        if (in_last_q && phase_d == PH_VALUE) begin
          res.err = ERR_TRUNCATED;
        end
      end

      default: begin
        if (in_last_q) begin
          res.err = err_latch_q;
        end
      end
    endcase

    // status-only results carry the next free bin after this byte
    if (!have) begin
      res.kind  = KIND_STATUS;
      res.bin   = BinW'(next_bin_d);
      res.value = '0;
      res.run   = RunW'(1);
    end

    // frame end returns everything to reset
    if (in_last_q) begin
      phase_d     = PH_WORDS;
      byte_pos_d  = '0;
      asm_d       = '0;
      prev_d      = '0;
      left_d      = '0;
      wcode_d     = '0;
      next_bin_d  = '0;
      err_latch_d = ERR_NONE;
    end
  end

  // a group error gives its status word right away, the last byte always reports
  assign emit = have || in_last_q || (phase_d == PH_DROP && phase_q == PH_GROUP);

  // ------------------------------------------------------------------
  // handshake: the byte moves on when its result has room or it makes none
  // ------------------------------------------------------------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // byte payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= frame_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WORDS;
      byte_pos_q  <= '0;
      asm_q       <= '0;
      prev_q      <= '0;
      left_q      <= '0;
      wcode_q     <= '0;
      next_bin_q  <= '0;
      err_latch_q <= ERR_NONE;
    end else if (advance) begin
      phase_q     <= phase_d;
      byte_pos_q  <= byte_pos_d;
      asm_q       <= asm_d;
      prev_q      <= prev_d;
      left_q      <= left_d;
      wcode_q     <= wcode_d;
      next_bin_q  <= next_bin_d;
      err_latch_q <= err_latch_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign bin_index_o  = out_q.bin;
  assign value_word_o = $signed(out_q.value);
  assign run_length_o = out_q.run;
  assign error_code_o = out_q.err;
  assign frame_done_o = out_q.done;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  `SDD_ASSERT(a_bin_bound, clk_i, rst_ni, next_bin_q <= NbW'(SPECTRUM_BINS), "next bin beyond spectrum")
  `SDD_ASSERT(a_drop_latched, clk_i, rst_ni, phase_q != PH_DROP || err_latch_q != ERR_NONE, "drop without error")
  `SDD_ASSERT(a_value_left, clk_i, rst_ni, phase_q != PH_VALUE || left_q != '0, "value phase with no values left")
  `SDD_ASSERT_NEXT(a_frame_reset, clk_i, rst_ni, advance && in_last_q, phase_q == PH_WORDS && next_bin_q == '0 && byte_pos_q == '0, "frame end did not clear state")

endmodule
